// ===== rtl/core/lz4d_pkg.sv =====
package lz4d_pkg;

  // history addresses are carried at the widest window size
  localparam int unsigned ADDR_MAX_BITS = 16;

  localparam logic [3:0] NIBBLE_MASK  = 4'hf;
  localparam logic [7:0] EXT_CONTINUE = 8'hff;

  // item kinds
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_OFFSET   = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_TRUNC    = 3'd3;
  localparam logic [2:0] ERR_KIND     = 3'd4;

  // one classified item, front to back
  typedef struct packed {
    logic                     byte_valid;
    logic                     copy;
    logic [7:0]               lit_byte;
    logic [ADDR_MAX_BITS-1:0] raddr;
    logic [ADDR_MAX_BITS-1:0] waddr;
    logic                     ready_for_byte;
    logic                     block_done;
    logic [2:0]               error_code;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       ready_for_byte;
    logic       block_done;
    logic [2:0] error_code;
  } res_t;

endpackage

// ===== rtl/core/lz4d_front.sv =====
module lz4d_front #(
  parameter int unsigned WINDOW_BYTES = 65536,
  parameter int unsigned COUNT_BITS   = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [23:0]   cfg_max_output_bytes,
  input  logic          take,
  input  logic          operation,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output lz4d_pkg::cmd_t cmd
);
  import lz4d_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LIT_EXT, PH_LITERALS, PH_OFF_LO,
    PH_OFF_HI, PH_MATCH_EXT, PH_MATCH, PH_DONE
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] lit_r, lit_nxt, mat_r, mat_nxt, prod_r, prod_nxt;
  logic [15:0]           dist_r, dist_nxt;
  logic [AW-1:0]         wp_r, wp_nxt;
  logic [2:0]            err_r, err_nxt;
  logic [3:0]            mnib_r, mnib_nxt;
  logic [23:0]           max_r;
  logic                  ovf, emit, copy, done;
  logic [COUNT_BITS:0]   lit_sum, mat_sum;
  logic [15:0]           dist_full;
  logic [AW-1:0]         raddr;

  // room check for one more output byte
  assign ovf = (32'(prod_r) >= 32'(max_r)) || (prod_r == COUNT_MAX);

  // saturating length extension
  assign lit_sum   = {1'b0, lit_r} + (COUNT_BITS+1)'(data_byte);
  assign mat_sum   = {1'b0, mat_r} + (COUNT_BITS+1)'(data_byte);
  assign dist_full = {data_byte, dist_r[7:0]};
  assign raddr     = wp_r - dist_r[AW-1:0];

  // sequence decoder
  always_comb begin
    phase_nxt = phase_r;
    lit_nxt   = lit_r;
    mat_nxt   = mat_r;
    dist_nxt  = dist_r;
    err_nxt   = err_r;
    mnib_nxt  = mnib_r;
    emit      = 1'b0;
    copy      = 1'b0;
    done      = 1'b0;
    if (err_r == ERR_NONE) begin
      if (phase_r == PH_DONE) begin
        err_nxt = ERR_KIND;
      end else if (phase_r == PH_MATCH) begin
        if (operation != OP_DRAIN) begin
          err_nxt = ERR_KIND;
        end else if (ovf) begin
          err_nxt = ERR_OVERFLOW;
        end else begin
          emit    = 1'b1;
          copy    = 1'b1;
          mat_nxt = mat_r - 1'b1;
          if (mat_r == COUNT_BITS'(1)) phase_nxt = PH_TOKEN;
        end
      end else if (operation != OP_BYTE) begin
        err_nxt = ERR_KIND;
      end else begin
        unique case (phase_r)
          PH_TOKEN: begin
            lit_nxt  = COUNT_BITS'(data_byte[7:4]);
            mnib_nxt = data_byte[3:0];
            if (data_byte[7:4] == NIBBLE_MASK) begin
              phase_nxt = PH_LIT_EXT;
              if (last_byte) err_nxt = ERR_TRUNC;
            end else if (data_byte[7:4] != 4'd0) begin
              phase_nxt = PH_LITERALS;
              if (last_byte) err_nxt = ERR_TRUNC;
            end else if (last_byte) begin
              phase_nxt = PH_DONE;
              done      = 1'b1;
            end else begin
              phase_nxt = PH_OFF_LO;
            end
          end
          PH_LIT_EXT: begin
            lit_nxt = lit_sum[COUNT_BITS] ? COUNT_MAX : lit_sum[COUNT_BITS-1:0];
            if (last_byte) err_nxt = ERR_TRUNC;
            else if (data_byte != EXT_CONTINUE) phase_nxt = PH_LITERALS;
          end
          PH_LITERALS: begin
            if (ovf) begin
              err_nxt = ERR_OVERFLOW;
            end else begin
              emit    = 1'b1;
              lit_nxt = lit_r - 1'b1;
              if (last_byte) begin
                if (lit_r == COUNT_BITS'(1)) begin
                  phase_nxt = PH_DONE;
                  done      = 1'b1;
                end else begin
                  err_nxt = ERR_TRUNC;
                end
              end else if (lit_r == COUNT_BITS'(1)) begin
                phase_nxt = PH_OFF_LO;
              end
            end
          end
          PH_OFF_LO: begin
            dist_nxt = {8'd0, data_byte};
            if (last_byte) err_nxt = ERR_TRUNC;
            else phase_nxt = PH_OFF_HI;
          end
          PH_OFF_HI: begin
            dist_nxt = dist_full;
            if (last_byte) begin
              err_nxt = ERR_TRUNC;
            end else if (dist_full == 16'd0 || 32'(dist_full) > 32'(prod_r)
                         || 32'(dist_full) > 32'(WINDOW_BYTES)) begin
              err_nxt = ERR_OFFSET;
            end else if (mnib_r == NIBBLE_MASK) begin
              phase_nxt = PH_MATCH_EXT;
              mat_nxt   = COUNT_BITS'(19);
            end else begin
              phase_nxt = PH_MATCH;
              mat_nxt   = COUNT_BITS'(mnib_r) + COUNT_BITS'(4);
            end
          end
          PH_MATCH_EXT: begin
            mat_nxt = mat_sum[COUNT_BITS] ? COUNT_MAX : mat_sum[COUNT_BITS-1:0];
            if (last_byte) err_nxt = ERR_TRUNC;
            else if (data_byte != EXT_CONTINUE) phase_nxt = PH_MATCH;
          end
          default: begin
            err_nxt = ERR_KIND;
          end
        endcase
      end
    end
    wp_nxt   = emit ? wp_r + 1'b1 : wp_r;
    prod_nxt = emit ? prod_r + 1'b1 : prod_r;
  end

  // command for the back end
  always_comb begin
    cmd                = '0;
    cmd.byte_valid     = emit && (err_nxt == ERR_NONE);
    cmd.copy           = copy;
    cmd.lit_byte       = data_byte;
    cmd.raddr          = ADDR_MAX_BITS'(raddr);
    cmd.waddr          = ADDR_MAX_BITS'(wp_r);
    cmd.ready_for_byte = (err_nxt == ERR_NONE) && (phase_nxt != PH_MATCH)
                         && (phase_nxt != PH_DONE);
    cmd.block_done     = done && (err_nxt == ERR_NONE);
    cmd.error_code     = err_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TOKEN;
      lit_r   <= '0;
      mat_r   <= '0;
      dist_r  <= '0;
      wp_r    <= '0;
      prod_r  <= '0;
      err_r   <= ERR_NONE;
      mnib_r  <= '0;
      max_r   <= 24'hffffff;
    end else begin
      if (cfg_we) max_r <= cfg_max_output_bytes;
      if (take) begin
        phase_r <= phase_nxt;
        lit_r   <= lit_nxt;
        mat_r   <= mat_nxt;
        dist_r  <= dist_nxt;
        wp_r    <= wp_nxt;
        prod_r  <= prod_nxt;
        err_r   <= err_nxt;
        mnib_r  <= mnib_nxt;
      end
    end
  end

`ifndef SYNTH
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE) |=> (err_r == $past(err_r)))
    else $error("latched error changed");
  a_no_emit_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE) |-> !cmd.byte_valid)
    else $error("byte emitted after error");
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cmd.block_done) |=> (phase_r == PH_DONE))
    else $error("done without entering done phase");
`endif

endmodule

// ===== rtl/core/lz4d_cmdq.sv =====
module lz4d_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  lz4d_pkg::cmd_t wdata,
  output logic           full,
  input  logic           rd,
  output lz4d_pkg::cmd_t rdata,
  output logic           empty
);
  import lz4d_pkg::*;

  cmd_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign rdata = mem_r[rp_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
  end

`ifndef SYNTH
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n) wr |-> !full)
    else $error("command queue overflow");
  a_no_unf: assert property (@(posedge clk) disable iff (!rst_n) rd |-> !empty)
    else $error("command queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("command queue count out of range");
`endif

endmodule

// ===== rtl/core/lz4d_back.sv =====
module lz4d_back #(
  parameter int unsigned WINDOW_BYTES = 65536
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lz4d_pkg::cmd_t q_cmd,
  input  logic           q_empty,
  output logic           q_rd,
  output lz4d_pkg::res_t res,
  output logic           empty,
  input  logic           pop
);
  import lz4d_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_BYTES);

  logic [7:0] hist_r [WINDOW_BYTES];
  cmd_t       s1_r;
  logic       s1_vld_r;
  logic [7:0] rdata_r, fwd_byte_r, s1_byte;
  logic       fwd_r, s1_wr, opop;
  res_t       ofifo_r [4];
  logic [1:0] owp_r, orp_r;
  logic [2:0] ocnt_r;
  logic [3:0] pending;
  res_t       s1_res;

  // issue only while the result queue has room for everything in flight
  assign pending = 4'(ocnt_r) + 4'(s1_vld_r);
  assign q_rd    = !q_empty && (pending < 4'd4);
  assign opop    = pop && !empty;
  assign empty   = (ocnt_r == 3'd0);
  assign res     = ofifo_r[orp_r];

  // byte of the stage: literal, forwarded, or read from history
  assign s1_byte = !s1_r.copy ? s1_r.lit_byte : (fwd_r ? fwd_byte_r : rdata_r);
  assign s1_wr   = s1_vld_r && s1_r.byte_valid;

  always_comb begin
    s1_res.byte_valid     = s1_r.byte_valid;
    s1_res.out_byte       = s1_r.byte_valid ? s1_byte : 8'd0;
    s1_res.ready_for_byte = s1_r.ready_for_byte;
    s1_res.block_done     = s1_r.block_done;
    s1_res.error_code     = s1_r.error_code;
  end

  // history window: one write, one registered read
  always_ff @(posedge clk) begin
    if (s1_wr) hist_r[s1_r.waddr[AW-1:0]] <= s1_byte;
    if (q_rd) rdata_r <= hist_r[q_cmd.raddr[AW-1:0]];
  end

  // stage register and forwarding of the byte written this cycle
  always_ff @(posedge clk) begin
    if (q_rd) begin
      s1_r       <= q_cmd;
      fwd_r      <= s1_wr && (s1_r.waddr[AW-1:0] == q_cmd.raddr[AW-1:0]);
      fwd_byte_r <= s1_byte;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (s1_vld_r) ofifo_r[owp_r] <= s1_res;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      owp_r    <= '0;
      orp_r    <= '0;
      ocnt_r   <= '0;
    end else begin
      s1_vld_r <= q_rd;
      if (s1_vld_r) owp_r <= owp_r + 1'b1;
      if (opop) orp_r <= orp_r + 1'b1;
      ocnt_r <= ocnt_r + 3'(s1_vld_r) - 3'(opop);
    end
  end

`ifndef SYNTH
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (ocnt_r < 3'd4) || opop)
    else $error("result queue overflow");
  a_valid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && res.byte_valid) |-> (res.error_code == ERR_NONE))
    else $error("byte with error");
  a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && res.block_done) |-> !res.ready_for_byte)
    else $error("done result still asks for bytes");
`endif

endmodule

// ===== rtl/core/lz4_block_decompressor_top.sv =====
// LZ4 block decompressor.
// Input queue side: push/full with in_operation (0 = compressed byte,
// 1 = drain tick for one match byte), in_data_byte and in_last_byte.
// A transfer happens when push is high and full is low.
// Result queue side: empty/pop; each input item yields exactly one result
// (out_byte_valid, out_out_byte, out_ready_for_byte, out_block_done,
// out_error_code), transferred when pop is high and empty is low.
// cfg_we/cfg_max_output_bytes set the output capacity while idle.
// Throughput is one item per cycle in both directions while full and empty
// are low. The decoded command passes through the command queue, the
// history stage register and the result queue, in that order, before the
// result is visible.
// The 64 KiB history is a single-port-write, single-read synchronous RAM;
// a copy of the byte written in the same cycle is forwarded.
// Reset clears decoder state, queues and the latched error; history is not
// cleared. When the receiver stalls, the result queue (4 entries) and
// command queue (4 entries) fill and full rises; nothing is dropped.
module lz4_block_decompressor_top #(
  parameter int unsigned WINDOW_BYTES = 65536,
  parameter int unsigned COUNT_BITS   = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_max_output_bytes,
  input  logic        push,
  output logic        full,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_byte_valid,
  output logic [7:0]  out_out_byte,
  output logic        out_ready_for_byte,
  output logic        out_block_done,
  output logic [2:0]  out_error_code
);
  import lz4d_pkg::*;

  cmd_t cmd, q_cmd;
  res_t res;
  logic take, q_rd, q_empty;

  assign take = push && !full;

  lz4d_front #(.WINDOW_BYTES(WINDOW_BYTES), .COUNT_BITS(COUNT_BITS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_max_output_bytes, .take,
    .operation(in_operation), .data_byte(in_data_byte), .last_byte(in_last_byte),
    .cmd
  );

  lz4d_cmdq u_cmdq (
    .clk, .rst_n, .wr(take), .wdata(cmd), .full,
    .rd(q_rd), .rdata(q_cmd), .empty(q_empty)
  );

  lz4d_back #(.WINDOW_BYTES(WINDOW_BYTES)) u_back (
    .clk, .rst_n, .q_cmd, .q_empty, .q_rd, .res, .empty, .pop
  );

  assign out_byte_valid     = res.byte_valid;
  assign out_out_byte       = res.out_byte;
  assign out_ready_for_byte = res.ready_for_byte;
  assign out_block_done     = res.block_done;
  assign out_error_code     = res.error_code;

endmodule

// ===== tb/lz4_block_decompressor_top_test.sv =====
module lz4_block_decompressor_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lz4d_pkg::*;

  localparam int unsigned WINDOW     = 65536;
  localparam int unsigned SAT_MAX    = 32'h00ff_ffff;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned RAND_ITEMS = 1400;

  typedef enum logic [2:0] {
    DEC_TOKEN, DEC_LIT_EXT, DEC_LITERALS, DEC_OFF_LO,
    DEC_OFF_HI, DEC_MATCH_EXT, DEC_MATCH, DEC_DONE
  } dec_phase_t;

  // ending chosen per seed
  typedef enum int {
    END_CLEAN, END_TRUNC, END_BAD_OFFSET, END_WRONG_KIND, END_OVERFLOW
  } ending_t;

  typedef struct {
    logic op;
    logic [7:0] data;
    logic last;
    bit typed;
    res_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_max_output_bytes = 24'd0;
  logic        push = 1'b0;
  logic        full;
  logic        in_operation = OP_BYTE;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_byte_valid;
  logic [7:0]  out_out_byte;
  logic        out_ready_for_byte;
  logic        out_block_done;
  logic [2:0]  out_error_code;

  lz4_block_decompressor_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_max_output_bytes(cfg_max_output_bytes),
    .push(push), .full(full),
    .in_operation(in_operation), .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .empty(empty), .pop(pop),
    .out_byte_valid(out_byte_valid), .out_out_byte(out_out_byte),
    .out_ready_for_byte(out_ready_for_byte), .out_block_done(out_block_done),
    .out_error_code(out_error_code)
  );

  // decoder mirror
  logic [7:0]  win_mem [WINDOW];
  dec_phase_t  dec_phase = DEC_TOKEN;
  int unsigned lit_left = 0;
  int unsigned copy_left = 0;
  int unsigned copy_dist = 0;
  logic [15:0] wr_ptr = '0;
  int unsigned out_count = 0;
  logic [2:0]  err_hold = ERR_NONE;
  logic [23:0] out_cap = 24'hff_ffff;
  logic [3:0]  copy_nib = '0;

  res_t        decoded_q [$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          cycles = 0;
  int          send_calm = 0;
  int          recv_calm = 0;
  int          recv_stall = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
    return (a + b > SAT_MAX) ? SAT_MAX : a + b;
  endfunction

  // store one byte into the window; 0 means overflow was latched
  function automatic bit put_byte(logic [7:0] b);
    if (out_count >= out_cap || out_count >= SAT_MAX) begin
      err_hold = ERR_OVERFLOW;
      return 1'b0;
    end
    win_mem[wr_ptr] = b;
    wr_ptr++;
    out_count++;
    return 1'b1;
  endfunction

  function automatic res_t decode_step(logic op, logic [7:0] b, logic last);
    res_t r;
    logic [7:0] v;
    r = '0;
    if (err_hold == ERR_NONE) begin
      if (dec_phase == DEC_DONE) begin
        err_hold = ERR_KIND;
      end else if (dec_phase == DEC_MATCH) begin
        if (op != OP_DRAIN) begin
          err_hold = ERR_KIND;
        end else begin
          v = win_mem[wr_ptr - copy_dist[15:0]];
          if (put_byte(v)) begin
            r.byte_valid = 1'b1;
            r.out_byte = v;
            copy_left--;
            if (copy_left == 0) dec_phase = DEC_TOKEN;
          end
        end
      end else if (op != OP_BYTE) begin
        err_hold = ERR_KIND;
      end else begin
        case (dec_phase)
          DEC_TOKEN: begin
            lit_left = b[7:4];
            copy_nib = b[3:0];
            if (b[7:4] == NIBBLE_MASK) begin
              dec_phase = DEC_LIT_EXT;
              if (last) err_hold = ERR_TRUNC;
            end else if (b[7:4] != 0) begin
              dec_phase = DEC_LITERALS;
              if (last) err_hold = ERR_TRUNC;
            end else if (last) begin
              dec_phase = DEC_DONE;
              r.block_done = 1'b1;
            end else begin
              dec_phase = DEC_OFF_LO;
            end
          end
          DEC_LIT_EXT: begin
            lit_left = sat_sum(lit_left, b);
            if (last) err_hold = ERR_TRUNC;
            else if (b != EXT_CONTINUE) dec_phase = DEC_LITERALS;
          end
          DEC_LITERALS: begin
            if (put_byte(b)) begin
              r.byte_valid = 1'b1;
              r.out_byte = b;
              lit_left--;
              if (last) begin
                if (lit_left == 0) begin
                  dec_phase = DEC_DONE;
                  r.block_done = 1'b1;
                end else begin
                  err_hold = ERR_TRUNC;
                end
              end else if (lit_left == 0) begin
                dec_phase = DEC_OFF_LO;
              end
            end
          end
          DEC_OFF_LO: begin
            copy_dist = b;
            if (last) err_hold = ERR_TRUNC;
            else dec_phase = DEC_OFF_HI;
          end
          DEC_OFF_HI: begin
            copy_dist = copy_dist | (int'(b) << 8);
            if (last) err_hold = ERR_TRUNC;
            else if (copy_dist == 0 || copy_dist > out_count || copy_dist > WINDOW)
              err_hold = ERR_OFFSET;
            else if (copy_nib == NIBBLE_MASK) begin
              copy_left = 19;
              dec_phase = DEC_MATCH_EXT;
            end else begin
              copy_left = copy_nib + 4;
              dec_phase = DEC_MATCH;
            end
          end
          default: begin
            copy_left = sat_sum(copy_left, b);
            if (last) err_hold = ERR_TRUNC;
            else if (b != EXT_CONTINUE) dec_phase = DEC_MATCH;
          end
        endcase
      end
    end
    if (err_hold != ERR_NONE) begin
      r.byte_valid = 1'b0;
      r.out_byte = '0;
      r.block_done = 1'b0;
    end
    r.ready_for_byte = (err_hold == ERR_NONE && dec_phase != DEC_MATCH &&
                        dec_phase != DEC_DONE);
    r.error_code = err_hold;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    fail_count++;
  endtask

  // one input transfer, with the expected result queued
  task automatic send_item(logic op, logic [7:0] b, logic last, bit typed, res_t typed_res);
    int gap;
    res_t r;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_operation <= op;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (full);
    r = decode_step(op, b, last);
    decoded_q.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    send_item(OP_BYTE, b, last, 1'b0, '0);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap(logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_max_output_bytes <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    out_cap = v;
  endtask

  task automatic drain_copy();
    while (dec_phase == DEC_MATCH && err_hold == ERR_NONE)
      send_item(OP_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'b0, '0);
  endtask

  // length extension bytes; cut counts down to the byte that carries last
  task automatic send_ext(int unsigned rem, inout int cut);
    while (rem >= 255) begin
      send_byte(8'hff, cut == 0);
      cut--;
      rem -= 255;
    end
    send_byte(rem[7:0], cut == 0);
    cut--;
  endtask

  // one sequence with random content
  task automatic send_sequence(bit final_seq, int cut, bit bad_off);
    int unsigned nl, ml, lim, off;
    logic [3:0] hi_nib, lo_nib;
    nl = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 300) : $urandom_range(0, 14);
    if (nl == 0 && (out_count == 0 || $urandom_range(0, 1))) nl = 1;
    if (final_seq && $urandom_range(0, 3) == 0) nl = 0;
    ml = ($urandom_range(0, 9) == 0) ? $urandom_range(19, 300) : $urandom_range(4, 18);
    hi_nib = (nl >= 15) ? 4'hf : nl[3:0];
    lo_nib = (ml - 4 >= 15) ? 4'hf : 4'(ml - 4);
    send_byte({hi_nib, lo_nib}, (final_seq && nl == 0) || cut == 0);
    cut--;
    if (nl >= 15) send_ext(nl - 15, cut);
    for (int unsigned i = 0; i < nl; i++) begin
      send_byte(8'($urandom_range(0, 255)), (final_seq && i == nl - 1) || cut == 0);
      cut--;
    end
    if (final_seq) return;
    lim = (out_count > 65535) ? 65535 : out_count;
    if (bad_off) off = ($urandom_range(0, 1) || out_count >= 65535) ? 0 : out_count + 1;
    else off = (lim == 0) ? 1 : $urandom_range(1, lim);
    send_byte(off[7:0], cut == 0);
    cut--;
    send_byte(off[15:8], cut == 0);
    cut--;
    if (lo_nib == NIBBLE_MASK) send_ext(ml - 19, cut);
    drain_copy();
  endtask

  task automatic send_noise(int n);
    repeat (n) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  // result side: random pops, field-by-field compare
  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected result, queue depth", 0, 1);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", out_byte_valid, want.byte_valid);
        if (out_out_byte !== want.out_byte)
          report_mismatch("out_byte", out_out_byte, want.out_byte);
        if (out_ready_for_byte !== want.ready_for_byte)
          report_mismatch("ready_for_byte", out_ready_for_byte, want.ready_for_byte);
        if (out_block_done !== want.block_done)
          report_mismatch("block_done", out_block_done, want.block_done);
        if (out_error_code !== want.error_code)
          report_mismatch("error_code", out_error_code, want.error_code);
      end
    end
    if (recv_stall > 0) begin
      recv_stall--;
      pop <= 1'b0;
    end else begin
      recv_stall = pick_gap(recv_calm);
      pop <= (recv_stall == 0);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    ending_t ending;
    int cut;
    for (int i = 0; i < WINDOW; i++) win_mem[i] = '0;

    // two literals, then a copy at distance 2 repeats them three times
    rows.push_back('{OP_BYTE, 8'h22, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE}});
    rows.push_back('{OP_BYTE, 8'hff, 1'b0, 1'b1, '{1'b1, 8'hff, 1'b1, 1'b0, ERR_NONE}});
    rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, 1'b1, 1'b0, ERR_NONE}});
    rows.push_back('{OP_BYTE, 8'h02, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b0, ERR_NONE}});
    rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE}});
    for (int i = 0; i < 6; i++)
      rows.push_back('{OP_DRAIN, 8'h5a, i[0], 1'b1,
                       '{1'b1, i[0] ? 8'h00 : 8'hff, i == 5, 1'b0, ERR_NONE}});
    // overlapping copy at distance 1
    rows.push_back('{OP_BYTE, 8'h10, 1'b0, 1'b0, '0});
    rows.push_back('{OP_BYTE, 8'ha5, 1'b0, 1'b0, '0});
    rows.push_back('{OP_BYTE, 8'h01, 1'b0, 1'b0, '0});
    rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b0, '0});
    for (int i = 0; i < 4; i++) rows.push_back('{OP_DRAIN, 8'h00, 1'b0, 1'b0, '0});
    // no literals, distance one short of all output, extended match length
    rows.push_back('{OP_BYTE, 8'h0f, 1'b0, 1'b0, '0});
    rows.push_back('{OP_BYTE, 8'h0c, 1'b0, 1'b0, '0});
    rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b0, '0});
    rows.push_back('{OP_BYTE, 8'hff, 1'b0, 1'b0, '0});
    rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b0, '0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_cap(24'hff_ffff);

    foreach (rows[i]) send_item(rows[i].op, rows[i].data, rows[i].last,
                                rows[i].typed, rows[i].res);
    drain_copy();

    while (items_sent < RAND_ITEMS / 2) send_sequence(1'b0, -1, 1'b0);
    wait_idle();
    write_cap(24'($urandom_range(200000, 24'hff_fffe)));
    while (items_sent < RAND_ITEMS) send_sequence(1'b0, -1, 1'b0);
    wait_idle();

    // the block ends once per run: pick how
    ending = ending_t'($urandom_range(0, 4));
    case (ending)
      END_CLEAN: send_sequence(1'b1, -1, 1'b0);
      END_TRUNC: begin
        cut = $urandom_range(0, 6);
        send_sequence(1'b0, cut, 1'b0);
      end
      END_BAD_OFFSET: send_sequence(1'b0, -1, 1'b1);
      END_WRONG_KIND: begin
        if ($urandom_range(0, 1)) begin
          send_item(OP_DRAIN, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end else begin
          send_byte(8'h10, 1'b0);
          send_byte(8'($urandom_range(0, 255)), 1'b0);
          send_byte(8'h01, 1'b0);
          send_byte(8'h00, 1'b0);
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      default: begin
        write_cap(24'(out_count + $urandom_range(1, 30)));
        while (err_hold == ERR_NONE) send_sequence(1'b0, -1, 1'b0);
      end
    endcase
    send_noise(8);
    wait_idle();
    write_cap(24'd1);
    send_noise(6);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
